// ----- hw/rtl/crec_pkg.sv -----
// Shared types and constants of the common row elements counter.
// No dependencies; every other file refers to this one by scoped names.
package crec_pkg;

  localparam int unsigned MAX_ROWS = 16;
  localparam int unsigned MAX_COLS = 16;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SIZE_W  = 5;                       // width of row_count, col_count
  localparam int unsigned CNT_W   = $clog2(MAX_ROWS + 1);    // entry count, 0..MAX_ROWS
  localparam int unsigned ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned USED_W  = $clog2(MAX_COLS + 1);
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAPTURE,
    ST_EMIT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the element on in_element_value
    logic capture;   // latch the mask of complete entries
    logic emit;      // send one result beat
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_elem;   // element now at the input closes the matrix
    logic drain_done;  // the beat being sent now is the final one
  } dp_status_t;

endpackage

// ----- hw/rtl/crec_ctrl.sv -----
// Controller of the common row elements counter: accept, capture, drain.
// Depends on crec_pkg.
module crec_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  crec_pkg::dp_status_t  status,
  output crec_pkg::dp_cmd_t     cmd
);

  crec_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    busy        = 1'b1;
    case (state_r)
      crec_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (status.last_elem) begin
            state_nxt = crec_pkg::ST_CAPTURE;
          end
        end
      end
      crec_pkg::ST_CAPTURE: begin
        cmd.capture = 1'b1;
        state_nxt   = crec_pkg::ST_EMIT;
      end
      crec_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.drain_done) begin
          state_nxt = crec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = crec_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/crec_dp.sv -----
// Datapath of the common row elements counter: size registers, entry table,
// positions, drain mask and result registers. Depends on crec_pkg.
module crec_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [crec_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [crec_pkg::SIZE_W-1:0]           cfg_wdata,
  input  logic signed [crec_pkg::DATA_W-1:0]    in_element_value,
  input  crec_pkg::dp_cmd_t                     cmd,
  output crec_pkg::dp_status_t                  status,
  output logic                                  out_valid,
  output logic signed [crec_pkg::DATA_W-1:0]    out_common_value,
  output logic                                  out_found,
  output logic                                  out_last_result
);

  logic [crec_pkg::SIZE_W-1:0]   row_count_r, row_count_nxt;
  logic [crec_pkg::SIZE_W-1:0]   col_count_r, col_count_nxt;
  logic [crec_pkg::DATA_W-1:0]   values_r [crec_pkg::MAX_COLS];
  logic [crec_pkg::DATA_W-1:0]   values_nxt [crec_pkg::MAX_COLS];
  logic [crec_pkg::CNT_W-1:0]    counts_r [crec_pkg::MAX_COLS];
  logic [crec_pkg::CNT_W-1:0]    counts_nxt [crec_pkg::MAX_COLS];
  logic [crec_pkg::USED_W-1:0]   used_r, used_nxt;
  logic [crec_pkg::ROW_W-1:0]    row_pos_r, row_pos_nxt;
  logic [crec_pkg::COL_W-1:0]    col_pos_r, col_pos_nxt;
  logic [crec_pkg::MAX_COLS-1:0] mask_r, mask_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [crec_pkg::DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                          out_found_r, out_found_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [crec_pkg::CNT_W-1:0]    rows_eff;
  logic [crec_pkg::CNT_W-1:0]    cols_eff;
  logic [crec_pkg::CNT_W-1:0]    rows_m1;
  logic [crec_pkg::CNT_W-1:0]    cols_m1;
  logic [crec_pkg::MAX_COLS-1:0] valid;
  logic [crec_pkg::MAX_COLS-1:0] match;
  logic [crec_pkg::MAX_COLS-1:0] mask_rest;
  logic [crec_pkg::COL_W-1:0]    pick;
  logic                          hit;
  logic                          col_end;
  logic                          row_end;

  // out-of-range sizes: zero acts as one, too large acts as the maximum
  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = crec_pkg::CNT_W'(1);
    end else if (crec_pkg::CNT_W'(row_count_r) > crec_pkg::CNT_W'(crec_pkg::MAX_ROWS) ||
                 row_count_r[crec_pkg::SIZE_W-1:0] > crec_pkg::SIZE_W'(crec_pkg::MAX_ROWS)) begin
      rows_eff = crec_pkg::CNT_W'(crec_pkg::MAX_ROWS);
    end else begin
      rows_eff = crec_pkg::CNT_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      cols_eff = crec_pkg::CNT_W'(1);
    end else if (crec_pkg::CNT_W'(col_count_r) > crec_pkg::CNT_W'(crec_pkg::MAX_COLS) ||
                 col_count_r[crec_pkg::SIZE_W-1:0] > crec_pkg::SIZE_W'(crec_pkg::MAX_COLS)) begin
      cols_eff = crec_pkg::CNT_W'(crec_pkg::MAX_COLS);
    end else begin
      cols_eff = crec_pkg::CNT_W'(col_count_r);
    end
    rows_m1 = rows_eff - crec_pkg::CNT_W'(1);
    cols_m1 = cols_eff - crec_pkg::CNT_W'(1);
  end

  assign col_end = (crec_pkg::CNT_W'(col_pos_r) == cols_m1);
  assign row_end = (crec_pkg::CNT_W'(row_pos_r) == rows_m1);

  always_comb begin
    for (int i = 0; i < crec_pkg::MAX_COLS; i++) begin
      valid[i] = (crec_pkg::USED_W'(i) < used_r);
      match[i] = valid[i] && (values_r[i] == in_element_value);
    end
  end

  assign hit = |match;

  // lowest pending entry of the drain
  always_comb begin
    pick = '0;
    for (int i = crec_pkg::MAX_COLS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick = crec_pkg::COL_W'(i);
      end
    end
  end

  assign mask_rest = mask_r & (mask_r - crec_pkg::MAX_COLS'(1));

  assign status.last_elem  = col_end && row_end;
  assign status.drain_done = (mask_rest == '0);

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    values_nxt    = values_r;
    counts_nxt    = counts_r;
    used_nxt      = used_r;
    row_pos_nxt   = row_pos_r;
    col_pos_nxt   = col_pos_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    if (cmd.accept) begin
      if (row_pos_r == '0) begin
        if (!hit && used_r < crec_pkg::USED_W'(crec_pkg::MAX_COLS)) begin
          values_nxt[used_r[crec_pkg::COL_W-1:0]] = in_element_value;
          counts_nxt[used_r[crec_pkg::COL_W-1:0]] = crec_pkg::CNT_W'(1);
          used_nxt = used_r + crec_pkg::USED_W'(1);
        end
      end else begin
        for (int i = 0; i < crec_pkg::MAX_COLS; i++) begin
          // a repeat in the same row counts once
          if (match[i] && counts_r[i] == crec_pkg::CNT_W'(row_pos_r)) begin
            counts_nxt[i] = counts_r[i] + crec_pkg::CNT_W'(1);
          end
        end
      end
      if (col_end) begin
        col_pos_nxt = '0;
        row_pos_nxt = row_end ? '0 : row_pos_r + crec_pkg::ROW_W'(1);
      end else begin
        col_pos_nxt = col_pos_r + crec_pkg::COL_W'(1);
      end
    end

    if (cmd.capture) begin
      for (int i = 0; i < crec_pkg::MAX_COLS; i++) begin
        mask_nxt[i] = valid[i] && (counts_r[i] == rows_eff);
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = |mask_r;
      out_value_nxt = (|mask_r) ? values_r[pick] : '0;
      out_last_nxt  = (mask_rest == '0);
      mask_nxt      = mask_rest;
      if (mask_rest == '0) begin
        for (int i = 0; i < crec_pkg::MAX_COLS; i++) begin
          counts_nxt[i] = '0;
        end
        used_nxt = '0;
      end
    end

    // any register write drops the matrix in progress
    if (cfg_we) begin
      if (cfg_index == crec_pkg::REG_ROW_COUNT) begin
        row_count_nxt = cfg_wdata;
      end else begin
        col_count_nxt = cfg_wdata;
      end
      for (int i = 0; i < crec_pkg::MAX_COLS; i++) begin
        counts_nxt[i] = '0;
      end
      used_nxt    = '0;
      row_pos_nxt = '0;
      col_pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= crec_pkg::SIZE_W'(4);
      col_count_r <= crec_pkg::SIZE_W'(5);
      for (int i = 0; i < crec_pkg::MAX_COLS; i++) begin
        counts_r[i] <= '0;
      end
      used_r      <= '0;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      counts_r    <= counts_nxt;
      used_r      <= used_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    values_r    <= values_nxt;
    out_value_r <= out_value_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_common_value = out_value_r;
  assign out_found        = out_found_r;
  assign out_last_result  = out_last_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= crec_pkg::USED_W'(crec_pkg::MAX_COLS))
    else $error("entry table overfilled");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_last_r)
    else $error("not-found beat without last mark");

  a_table_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> used_r == '0)
    else $error("table not cleared after final beat");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    crec_pkg::CNT_W'(row_pos_r) < rows_eff)
    else $error("row position beyond row count");

  a_emit_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.emit)
    else $error("drain did not follow capture");
`endif

endmodule

// ----- hw/rtl/common_row_elements_counter.sv -----
// Top level of the common row elements counter.
// Depends on crec_pkg, crec_ctrl and crec_dp.
//
// Usage: write row_count (index 0) and col_count (index 1) through cfg_we,
// cfg_index and cfg_wdata while the block is idle; any write starts a fresh
// matrix. Feed elements in row-major order: an element is taken on a clock
// edge with start high and busy low, one per cycle. Each element is compared
// against all table entries at once, which sets the one-element-per-cycle
// load rate. The last element raises busy. In the capture state the complete
// entries are latched, then one result beat per cycle follows on out_valid
// with out_common_value, out_found and out_last_result; each beat is
// registered from an emit state of the controller. k common values take k
// beats (one beat with out_found low when there are none), and busy stays
// high through the capture and emit states; the next matrix may start while
// the final beat is still on the outputs. The receiver cannot stall: each
// beat is valid for exactly one cycle. Reset restores 4 rows by 5 columns,
// empties the table and needs no clearing pass.
module common_row_elements_counter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [crec_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [crec_pkg::SIZE_W-1:0]           cfg_wdata,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [crec_pkg::DATA_W-1:0]    in_element_value,
  output logic                                  out_valid,
  output logic signed [crec_pkg::DATA_W-1:0]    out_common_value,
  output logic                                  out_found,
  output logic                                  out_last_result
);

  crec_pkg::dp_cmd_t    cmd;
  crec_pkg::dp_status_t status;

  crec_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  crec_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_element_value (in_element_value),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_common_value (out_common_value),
    .out_found        (out_found),
    .out_last_result  (out_last_result)
  );

endmodule
